// File: src/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation block
package ptc_pkg;

	// configuration port geometry
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	// register indexes (byte address = 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TEMPERATURE_COEFF      = 3'd5;

	// temperature thresholds in hundredths of a degree
	localparam int TEMP_REF = 2000;
	localparam int TEMP_LOW = -1500;

	// second-order correction factors
	localparam int OFF2_WARM_K  = 61;
	localparam int SENS2_WARM_K = 29;
	localparam int OFF2_COLD_K  = 17;
	localparam int SENS2_COLD_K = 9;

	// output saturation limits
	localparam int OUT_MAX = 8388607;
	localparam int OUT_MIN = -8388608;

	typedef struct packed {
		logic [23:0] raw_temperature;
		logic [23:0] raw_pressure;
	} in_t;

	typedef struct packed {
		logic signed [23:0] temperature_hundredths;
		logic signed [23:0] pressure_hundredths;
	} out_t;

	typedef struct packed {
		logic [15:0] pressure_sensitivity;
		logic [15:0] pressure_offset;
		logic [15:0] sensitivity_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] reference_temperature;
		logic [15:0] temperature_coeff;
	} cal_t;

	// hand-off from the temperature half to the pressure half
	typedef struct packed {
		logic signed [23:0] temperature_hundredths;
		logic signed [47:0] off_base;
		logic signed [47:0] sens_base;
		logic [34:0]        dsq;
		logic [34:0]        csq;
		logic               cold;
		logic               very_cold;
		logic [23:0]        raw_pressure;
	} mid_t;

endpackage

// File: src/pressure_temperature_compensation.sv
// An accepted request passes through nine register stages to its result on out_data.
// Throughput: one request per cycle while no result waits on out_ready.
// The whole pipeline advances together and holds while a result waits on out_ready.
// Reset clears the stage valid bits and sets all six calibration words to zero.
// Top level of the barometric pressure/temperature compensation pipeline
module pressure_temperature_compensation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ptc_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ptc_pkg::out_t               out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import ptc_pkg::*;

	cal_t cal;
	mid_t mid;
	logic mid_valid;
	logic adv;

	// pipeline moves whenever the output register is empty or being drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	ptc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	ptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.cal       (cal),
		.mid_valid (mid_valid),
		.mid       (mid)
	);

	ptc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.mid_valid (mid_valid),
		.mid       (mid),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// File: src/ptc_regs.sv
// APB register file holding the six calibration words
module ptc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output ptc_pkg::cal_t                cal
);
	import ptc_pkg::*;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	logic [15:0]          rd_word;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// calibration word writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_PRESSURE_SENSITIVITY:   cal.pressure_sensitivity   <= pwdata[15:0];
				REG_PRESSURE_OFFSET:        cal.pressure_offset        <= pwdata[15:0];
				REG_SENSITIVITY_TEMP_COEFF: cal.sensitivity_temp_coeff <= pwdata[15:0];
				REG_OFFSET_TEMP_COEFF:      cal.offset_temp_coeff      <= pwdata[15:0];
				REG_REFERENCE_TEMPERATURE:  cal.reference_temperature  <= pwdata[15:0];
				REG_TEMPERATURE_COEFF:      cal.temperature_coeff      <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_PRESSURE_SENSITIVITY:   rd_word = cal.pressure_sensitivity;
			REG_PRESSURE_OFFSET:        rd_word = cal.pressure_offset;
			REG_SENSITIVITY_TEMP_COEFF: rd_word = cal.sensitivity_temp_coeff;
			REG_OFFSET_TEMP_COEFF:      rd_word = cal.offset_temp_coeff;
			REG_REFERENCE_TEMPERATURE:  rd_word = cal.reference_temperature;
			REG_TEMPERATURE_COEFF:      rd_word = cal.temperature_coeff;
			default:                    rd_word = '0;
		endcase
	end

	assign prdata = {16'h0000, rd_word};

endmodule

// File: src/ptc_front.sv
// Stages 1-4: dT, first-order temperature, T2, offset/sensitivity bases, squares
module ptc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  ptc_pkg::in_t   in_data,
	input  ptc_pkg::cal_t  cal,
	output logic           mid_valid,
	output ptc_pkg::mid_t  mid
);
	import ptc_pkg::*;

	logic v_s1, v_s2, v_s3;

	// stage 1 registers
	logic signed [24:0] dt_s1;
	logic [23:0]        d1_s1;
	// stage 2 registers
	logic signed [41:0] tprod_s2;
	logic signed [41:0] oprod_s2;
	logic signed [41:0] sprod_s2;
	logic [48:0]        sq_s2;
	logic [23:0]        d1_s2;
	// stage 3 registers
	logic signed [18:0] temp_s3;
	logic [16:0]        t2c_s3;
	logic [12:0]        t2w_s3;
	logic signed [47:0] offb_s3;
	logic signed [47:0] sensb_s3;
	logic [23:0]        d1_s3;

	// combinational terms
	logic signed [24:0] dt_c;
	logic signed [16:0] c6_c, c4_c, c3_c;
	logic signed [49:0] sqfull_c;
	logic signed [18:0] temp_c;
	logic [50:0]        sq3_c, sq5_c;
	logic signed [47:0] offb_c, sensb_c;
	logic signed [19:0] dtemp_c, ctemp_c;
	logic signed [39:0] dsqf_c, csqf_c;
	logic               cold_c, very_c;
	logic [16:0]        t2_c;
	logic signed [19:0] tout_c;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			mid_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			mid_valid <= v_s3;
		end
	end

	// stage 1: dT = D2 - C5 * 2^8
	assign dt_c = $signed({1'b0, in_data.raw_temperature})
		- $signed({1'b0, cal.reference_temperature, 8'h00});

	// stage 2: products of dT
	assign c6_c     = $signed({1'b0, cal.temperature_coeff});
	assign c4_c     = $signed({1'b0, cal.offset_temp_coeff});
	assign c3_c     = $signed({1'b0, cal.sensitivity_temp_coeff});
	assign sqfull_c = 50'(dt_s1) * 50'(dt_s1);

	// stage 3: first-order temperature, T2 candidates, offset and sensitivity bases
	assign temp_c  = 19'(tprod_s2 >>> 23) + 19'(TEMP_REF);
	assign sq3_c   = {2'b00, sq_s2} + {1'b0, sq_s2, 1'b0};
	assign sq5_c   = {sq_s2, 2'b00} + {2'b00, sq_s2};
	assign offb_c  = 48'($signed({1'b0, cal.pressure_offset, 17'h00000}))
		+ 48'(oprod_s2 >>> 6);
	assign sensb_c = 48'($signed({1'b0, cal.pressure_sensitivity, 16'h0000}))
		+ 48'(sprod_s2 >>> 7);

	// stage 4: range flags, squared distances, corrected temperature
	assign dtemp_c = 20'(temp_s3) - 20'(TEMP_REF);
	assign ctemp_c = 20'(temp_s3) - 20'(TEMP_LOW);
	assign dsqf_c  = 40'(dtemp_c) * 40'(dtemp_c);
	assign csqf_c  = 40'(ctemp_c) * 40'(ctemp_c);
	assign cold_c  = temp_s3 < 19'(TEMP_REF);
	assign very_c  = temp_s3 < 19'(TEMP_LOW);
	assign t2_c    = cold_c ? t2c_s3 : {4'h0, t2w_s3};
	// TEMP - T2 stays within +/-2^19, so the 24-bit limits are never reached
	assign tout_c  = 20'(temp_s3) - $signed({3'b000, t2_c});

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			dt_s1    <= dt_c;
			d1_s1    <= in_data.raw_pressure;

			tprod_s2 <= 42'(dt_s1) * 42'(c6_c);
			oprod_s2 <= 42'(dt_s1) * 42'(c4_c);
			sprod_s2 <= 42'(dt_s1) * 42'(c3_c);
			sq_s2    <= sqfull_c[48:0];
			d1_s2    <= d1_s1;

			temp_s3  <= temp_c;
			t2c_s3   <= sq3_c[49:33];
			t2w_s3   <= sq5_c[50:38];
			offb_s3  <= offb_c;
			sensb_s3 <= sensb_c;
			d1_s3    <= d1_s2;

			mid.temperature_hundredths <= 24'(tout_c);
			mid.off_base               <= offb_s3;
			mid.sens_base              <= sensb_s3;
			mid.dsq                    <= dsqf_c[34:0];
			mid.csq                    <= csqf_c[34:0];
			mid.cold                   <= cold_c;
			mid.very_cold              <= very_c;
			mid.raw_pressure           <= d1_s3;
		end
	end

endmodule

// File: src/ptc_back.sv
// Stages 5-9: second-order offset/sensitivity, pressure product, scaling, saturation
module ptc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           mid_valid,
	input  ptc_pkg::mid_t  mid,
	output logic           out_valid,
	output ptc_pkg::out_t  out_data
);
	import ptc_pkg::*;

	logic v_s5, v_s6, v_s7, v_s8;

	// stage 5 registers
	logic [42:0]        off2_s5, sens2_s5;
	logic signed [47:0] offb_s5, sensb_s5;
	logic [23:0]        d1_s5;
	logic signed [23:0] tout_s5;
	// stage 6 registers
	logic signed [47:0] off_s6, sens_s6;
	logic [23:0]        d1_s6;
	logic signed [23:0] tout_s6;
	// stage 7 registers
	logic [44:0]        plo_s7;
	logic signed [51:0] phi_s7;
	logic signed [47:0] off_s7;
	logic signed [23:0] tout_s7;
	// stage 8 registers
	logic signed [52:0] x_s8;
	logic signed [23:0] tout_s8;

	// combinational terms
	logic [42:0]        off2_a, off2_b, sens2_a, sens2_b;
	logic [42:0]        off2_c, sens2_c;
	logic [44:0]        plo_c;
	logic signed [51:0] phi_c;
	logic signed [52:0] x_c;
	logic signed [37:0] p_c;
	logic signed [23:0] psat_c;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s5      <= mid_valid;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			out_valid <= v_s8;
		end
	end

	// stage 5: second-order offset and sensitivity, zero at or above the reference
	assign off2_a  = 43'(mid.dsq) * 43'(OFF2_WARM_K);
	assign off2_b  = 43'(mid.csq) * 43'(OFF2_COLD_K);
	assign sens2_a = 43'(mid.dsq) * 43'(SENS2_WARM_K);
	assign sens2_b = 43'(mid.csq) * 43'(SENS2_COLD_K);
	assign off2_c  = mid.cold ? (off2_a >> 4) + (mid.very_cold ? off2_b : '0) : '0;
	assign sens2_c = mid.cold ? (sens2_a >> 4) + (mid.very_cold ? sens2_b : '0) : '0;

	// stage 7: D1 * SENS as two partial products split at bit 21
	assign plo_c = 45'(d1_s6) * 45'(sens_s6[20:0]);
	assign phi_c = 52'($signed({1'b0, d1_s6})) * 52'($signed(sens_s6[47:21]));

	// stage 8: floor(D1 * SENS / 2^21) - OFF
	assign x_c = 53'(phi_s7) + $signed({29'h0, plo_s7[44:21]}) - 53'(off_s7);

	// stage 9: scale by 2^-15 and saturate
	assign p_c = 38'(x_s8 >>> 15);
	always_comb begin
		priority if (p_c > 38'(OUT_MAX)) begin
			psat_c = 24'(OUT_MAX);
		end else if (p_c < 38'(OUT_MIN)) begin
			psat_c = 24'(OUT_MIN);
		end else begin
			psat_c = p_c[23:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			offb_s5  <= mid.off_base;
			sensb_s5 <= mid.sens_base;
			d1_s5    <= mid.raw_pressure;
			tout_s5  <= mid.temperature_hundredths;

			off_s6   <= offb_s5 - $signed({5'h00, off2_s5});
			sens_s6  <= sensb_s5 - $signed({5'h00, sens2_s5});
			d1_s6    <= d1_s5;
			tout_s6  <= tout_s5;

			plo_s7   <= plo_c;
			phi_s7   <= phi_c;
			off_s7   <= off_s6;
			tout_s7  <= tout_s6;

			x_s8     <= x_c;
			tout_s8  <= tout_s7;

			out_data.temperature_hundredths <= tout_s8;
			out_data.pressure_hundredths    <= psat_c;
		end
	end

endmodule
